// ===== src/csmh_pkg.sv =====
// shared types and constants for the cuboid stack height block
`timescale 1ns / 1ps

package csmh_pkg;

   localparam int MAX_BOXES_DEF = 64;
   localparam int DIM_BITS_DEF = 16;
   localparam int FIELD_W = 16;
   localparam int HEIGHT_W = 22;
   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = {HEIGHT_W{1'b1}};

   typedef struct packed {
      logic [FIELD_W-1:0] dim_first;
      logic [FIELD_W-1:0] dim_second;
      logic [FIELD_W-1:0] dim_third;
      logic last_box;
   } req_type;

   typedef struct packed {
      logic [HEIGHT_W-1:0] max_stack_height;
      logic overflowed;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load_key;   // latch sorted dims of the new item, pointer at count
      logic set_ovf;    // item dropped, store full
      logic rd_ins;     // read entry below the insertion pointer
      logic rd_i;       // read entry i
      logic rd_j;       // read entry j
      logic wr_key;     // place the new item at the insertion pointer
      logic wr_shift;   // move the read entry up one slot
      logic dp_init;    // start the height pass
      logic key_i;      // latch entry i as the upper box
      logic dp_cmp;     // fold entry j into the best height below
      logic wr_best;    // store the height of entry i
      logic clear;      // set done, start a new set
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic cnt_full;
      logic ptr_zero;
      logic ins_gt;
      logic last;
      logic i_done;
      logic j_done;
   } stat_type;

endpackage

// ===== src/csmh_ctrl.sv =====
// controller state machine for the cuboid stack height block
`timescale 1ns / 1ps

module csmh_ctrl
   import csmh_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     last_in,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy,
   output logic     rsp_strobe
);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_INS_RD  = 9'b000000010,
      ST_INS_CMP = 9'b000000100,
      ST_DP_LDI  = 9'b000001000,
      ST_DP_KEY  = 9'b000010000,
      ST_DP_RD   = 9'b000100000,
      ST_DP_CMP  = 9'b001000000,
      ST_DP_WR   = 9'b010000000,
      ST_DONE    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic accept;

   assign busy = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_DONE);
   assign accept = start && !busy;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_key = 1'b1;
               if (!stat.cnt_full) begin
                  state_in = ST_INS_RD;
               end else begin
                  cmd.set_ovf = 1'b1;
                  if (last_in) begin
                     cmd.dp_init = 1'b1;
                     state_in = ST_DP_LDI;
                  end
               end
            end
         end
         ST_INS_RD: begin
            if (stat.ptr_zero) begin
               cmd.wr_key = 1'b1;
               cmd.dp_init = stat.last;
               state_in = stat.last ? ST_DP_LDI : ST_IDLE;
            end else begin
               cmd.rd_ins = 1'b1;
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            if (stat.ins_gt) begin
               cmd.wr_shift = 1'b1;
               state_in = ST_INS_RD;
            end else begin
               cmd.wr_key = 1'b1;
               cmd.dp_init = stat.last;
               state_in = stat.last ? ST_DP_LDI : ST_IDLE;
            end
         end
         ST_DP_LDI: begin
            if (stat.i_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.rd_i = 1'b1;
               state_in = ST_DP_KEY;
            end
         end
         ST_DP_KEY: begin
            cmd.key_i = 1'b1;
            state_in = ST_DP_RD;
         end
         ST_DP_RD: begin
            if (stat.j_done) begin
               state_in = ST_DP_WR;
            end else begin
               cmd.rd_j = 1'b1;
               state_in = ST_DP_CMP;
            end
         end
         ST_DP_CMP: begin
            cmd.dp_cmp = 1'b1;
            state_in = ST_DP_RD;
         end
         ST_DP_WR: begin
            cmd.wr_best = 1'b1;
            state_in = ST_DP_LDI;
         end
         ST_DONE: begin
            cmd.clear = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // checks
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe && !busy)
      else $error("result strobe longer than one cycle");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (!stat.cnt_full || last_in)) |=> busy)
      else $error("item accepted but block not busy");
   a_done_after_wr: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_DP_LDI))
      else $error("result without finished height pass");

endmodule

// ===== src/csmh_dp.sv =====
// datapath for the cuboid stack height block: stores, pointers, compares
`timescale 1ns / 1ps

module csmh_dp
   import csmh_pkg::*;
#(
   parameter int MAX_BOXES = MAX_BOXES_DEF,
   parameter int DIM_BITS = DIM_BITS_DEF
)
(
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output rsp_type  rsp_data
);

   localparam int CNT_W = $clog2(MAX_BOXES + 1);
   localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int BOX_W = 3 * DIM_BITS;
   localparam int SUM_W = ((DIM_BITS > HEIGHT_W) ? DIM_BITS : HEIGHT_W) + 1;

   logic [BOX_W-1:0]    dims_mem [MAX_BOXES];
   logic [HEIGHT_W-1:0] best_mem [MAX_BOXES];

   logic [CNT_W-1:0]    count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic                last_ff;
   logic [CNT_W-1:0]    ptr_ff;
   logic [CNT_W-1:0]    i_ff, j_ff;
   logic [BOX_W-1:0]    key_ff;
   logic [BOX_W-1:0]    ki_ff;
   logic [HEIGHT_W-1:0] below_ff;
   logic [HEIGHT_W-1:0] max_ff;
   logic [BOX_W-1:0]    rd_dims_ff;
   logic [HEIGHT_W-1:0] rd_best_ff;

   logic [DIM_BITS-1:0] a0, a1, a2, b0, b1, c0, c1, c2;
   logic [BOX_W-1:0]    key_sorted;
   logic [CNT_W-1:0]    ptr_dec;
   logic [CNT_W-1:0]    rd_addr;
   logic [DIM_BITS-1:0] r0, r1, r2, k0, k1, k2, q0, q1, q2;
   logic                gt, dominated;
   logic [SUM_W-1:0]    h_sum;
   logic [HEIGHT_W-1:0] h_sat;

   // order the three dims ascending: three compare-swaps
   always_comb begin
      a0 = DIM_BITS'(req_data.dim_first);
      a1 = DIM_BITS'(req_data.dim_second);
      a2 = DIM_BITS'(req_data.dim_third);
      b0 = (a0 > a1) ? a1 : a0;
      b1 = (a0 > a1) ? a0 : a1;
      c2 = (b1 > a2) ? b1 : a2;
      c1 = (b1 > a2) ? a2 : b1;
      c0 = (b0 > c1) ? c1 : b0;
      if (b0 > c1) begin
         c1 = b0;
      end
      key_sorted = {c0, c1, c2};
   end

   assign ptr_dec = ptr_ff - CNT_W'(1);
   assign rd_addr = cmd.rd_ins ? ptr_dec : (cmd.rd_i ? i_ff : j_ff);
   assign {r0, r1, r2} = rd_dims_ff;
   assign {k0, k1, k2} = key_ff;
   assign {q0, q1, q2} = ki_ff;

   // lexicographic compare of the read entry against the new item
   assign gt = (r0 != k0) ? (r0 > k0) : ((r1 != k1) ? (r1 > k1) : (r2 > k2));
   assign dominated = (q0 >= r0) && (q1 >= r1) && (q2 >= r2) && (rd_best_ff > below_ff);

   // height of entry i with saturation
   assign h_sum = SUM_W'(below_ff) + SUM_W'(q2);
   assign h_sat = (h_sum > SUM_W'(HEIGHT_MAX)) ? HEIGHT_MAX : h_sum[HEIGHT_W-1:0];

   always_comb begin
      stat.cnt_full = (count_ff == CNT_W'(MAX_BOXES));
      stat.ptr_zero = (ptr_ff == '0);
      stat.ins_gt = gt;
      stat.last = last_ff;
      stat.i_done = (i_ff == count_ff);
      stat.j_done = (j_ff == i_ff);
   end

   assign rsp_data.max_stack_height = max_ff;
   assign rsp_data.overflowed = ovf_ff;

   // fill count and overflow flag
   always_comb begin
      count_in = count_ff;
      ovf_in = ovf_ff;
      if (cmd.wr_key) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.set_ovf) begin
         ovf_in = 1'b1;
      end
      if (cmd.clear) begin
         count_in = '0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff <= ovf_in;
      end
   end

   // pointers and working registers
   always_ff @(posedge clock) begin
      if (cmd.load_key) begin
         key_ff <= key_sorted;
         last_ff <= req_data.last_box;
         ptr_ff <= count_ff;
      end
      if (cmd.wr_shift) begin
         ptr_ff <= ptr_dec;
      end
      if (cmd.dp_init) begin
         i_ff <= '0;
         max_ff <= '0;
      end
      if (cmd.key_i) begin
         ki_ff <= rd_dims_ff;
         below_ff <= '0;
         j_ff <= '0;
      end
      if (cmd.dp_cmp) begin
         if (dominated) begin
            below_ff <= rd_best_ff;
         end
         j_ff <= j_ff + CNT_W'(1);
      end
      if (cmd.wr_best) begin
         i_ff <= i_ff + CNT_W'(1);
         if (h_sat > max_ff) begin
            max_ff <= h_sat;
         end
      end
   end

   // box and height stores
   always_ff @(posedge clock) begin
      if (cmd.rd_ins || cmd.rd_i || cmd.rd_j) begin
         rd_dims_ff <= dims_mem[rd_addr[IDX_W-1:0]];
         rd_best_ff <= best_mem[rd_addr[IDX_W-1:0]];
      end
      if (cmd.wr_key) begin
         dims_mem[ptr_ff[IDX_W-1:0]] <= key_ff;
      end else if (cmd.wr_shift) begin
         dims_mem[ptr_ff[IDX_W-1:0]] <= rd_dims_ff;
      end
      if (cmd.wr_best) begin
         best_mem[i_ff[IDX_W-1:0]] <= h_sat;
      end
   end

endmodule

// ===== src/cuboid_stack_max_height.sv =====
// top level of the cuboid stack height block
`timescale 1ns / 1ps

// Collects cuboids one item at a time (start while busy is low) until an item
// with last_box set, then reports the tallest stack in which every cuboid is
// dominated in all three sorted dims by the one below it; each cuboid adds its
// largest dim. Each stored item is inserted in sorted position, moving each
// larger entry up one slot through the single read port of the store. The last
// item then starts the height pass, which compares each entry i with every
// entry before it. The result appears for one cycle on rsp_strobe and must be
// taken then; the receiver cannot stall. Items beyond MAX_BOXES are dropped and
// flagged in overflowed.
module cuboid_stack_max_height
   import csmh_pkg::*;
#(
   parameter int MAX_BOXES = MAX_BOXES_DEF,
   parameter int DIM_BITS = DIM_BITS_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   csmh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .last_in    (req_data.last_box),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   csmh_dp #(
      .MAX_BOXES (MAX_BOXES),
      .DIM_BITS  (DIM_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

// ===== tb/cuboid_stack_max_height_checker.sv =====
// checker: watches the item and result channels, predicts stack heights and compares
`timescale 1ns / 1ps

module cuboid_stack_max_height_checker
   import csmh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count
);

   localparam int CAP = MAX_BOXES_DEF;

   logic [FIELD_W-1:0] boxes [CAP][3];
   int box_total;
   logic ovf_seen;
   rsp_type height_queue [$];

   // true when box a sorts after box b
   function automatic bit box_after(logic [FIELD_W-1:0] a [3], logic [FIELD_W-1:0] b [3]);
      if (a[0] != b[0]) return a[0] > b[0];
      if (a[1] != b[1]) return a[1] > b[1];
      return a[2] > b[2];
   endfunction

   // tallest stack over the held boxes
   function automatic logic [HEIGHT_W-1:0] tallest_stack();
      logic [FIELD_W-1:0] srt [CAP][3];
      logic [FIELD_W-1:0] key [3];
      logic [63:0] best [CAP];
      logic [63:0] below;
      logic [63:0] top;
      int j;
      top = 0;
      for (int i = 0; i < box_total; i++) srt[i] = boxes[i];
      // insertion sort, lexicographic
      for (int i = 1; i < box_total; i++) begin
         key = srt[i];
         j = i;
         while (j > 0 && box_after(srt[j-1], key)) begin
            srt[j] = srt[j-1];
            j--;
         end
         srt[j] = key;
      end
      for (int i = 0; i < box_total; i++) begin
         below = 0;
         for (int k = 0; k < i; k++)
            if (srt[i][0] >= srt[k][0] && srt[i][1] >= srt[k][1] &&
                srt[i][2] >= srt[k][2] && best[k] > below)
               below = best[k];
         best[i] = below + srt[i][2];
         if (best[i] > HEIGHT_MAX) best[i] = HEIGHT_MAX;
         if (best[i] > top) top = best[i];
      end
      return top[HEIGHT_W-1:0];
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // accept items and results
   always @(posedge clock) begin
      logic [FIELD_W-1:0] d [3];
      logic [FIELD_W-1:0] t;
      rsp_type exp_rsp;
      if (reset) begin
         box_total = 0;
         ovf_seen = 1'b0;
         fail_count = 0;
         pending_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (height_queue.size() == 0) begin
               $display("unexpected result at %0t", $realtime);
               fail_count++;
            end else begin
               exp_rsp = height_queue.pop_front();
               if (rsp_data.max_stack_height !== exp_rsp.max_stack_height)
                  report("max_stack_height", rsp_data.max_stack_height,
                         exp_rsp.max_stack_height);
               if (rsp_data.overflowed !== exp_rsp.overflowed)
                  report("overflowed", rsp_data.overflowed, exp_rsp.overflowed);
            end
         end
         if (start && !busy) begin
            if (box_total < CAP) begin
               d[0] = req_data.dim_first;
               d[1] = req_data.dim_second;
               d[2] = req_data.dim_third;
               if (d[0] > d[1]) begin t = d[0]; d[0] = d[1]; d[1] = t; end
               if (d[1] > d[2]) begin t = d[1]; d[1] = d[2]; d[2] = t; end
               if (d[0] > d[1]) begin t = d[0]; d[0] = d[1]; d[1] = t; end
               boxes[box_total] = d;
               box_total = box_total + 1;
            end else
               ovf_seen = 1'b1;
            if (req_data.last_box) begin
               exp_rsp.max_stack_height = tallest_stack();
               exp_rsp.overflowed = ovf_seen;
               height_queue.push_back(exp_rsp);
               box_total = 0;
               ovf_seen = 1'b0;
            end
         end
         pending_count = height_queue.size();
      end
   end

endmodule

// ===== tb/cuboid_stack_max_height_test.sv =====
// testbench top: drives cuboid items into the block and gives the verdict
`timescale 1ns / 1ps

module cuboid_stack_max_height_test;
   import csmh_pkg::*;

   localparam int IDLE_LIMIT = 40000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      quiet_cycles;
   bit      calm;

   cuboid_stack_max_height dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   cuboid_stack_max_height_checker check (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog on cycles with no accepted item or result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("cuboid_stack_max_height verification failed");
         $finish;
      end
   end

   // send one item, with random idle beforehand
   task automatic send_box(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
                           logic [FIELD_W-1:0] c, logic last);
      while (!calm && $urandom_range(99) < 23) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= '{dim_first: a, dim_second: b, dim_third: c, last_box: last};
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic [FIELD_W-1:0] rand_dim(int mode);
      case (mode)
         0: return FIELD_W'($urandom_range(8));
         1: return FIELD_W'($urandom);
         default: return FIELD_W'($urandom_range(65535, 65520));
      endcase
   endfunction

   // one random set of n boxes
   task automatic send_set(int n, int mode);
      for (int i = 0; i < n; i++)
         send_box(rand_dim(mode), rand_dim(mode), rand_dim(mode), i == n - 1);
   endtask

   initial begin
      int n;
      int sent;
      quiet_cycles = 0;
      calm = 1'b0;
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single boxes at the extremes, ties, a full store, overflow
      send_box(16'd0, 16'd0, 16'd0, 1'b1);
      send_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_box(16'd3, 16'd1, 16'd2, 1'b0);
      send_box(16'd2, 16'd3, 16'd1, 1'b0);
      send_box(16'd1, 16'd2, 16'd3, 1'b1);
      send_box(16'd5, 16'd5, 16'd1, 1'b0);
      send_box(16'd1, 16'd1, 16'd9, 1'b1);
      send_box(16'hAAAA, 16'h5555, 16'h0F0F, 1'b1);
      for (int i = 0; i < 64; i++) send_box(16'hFFFF, 16'hFFFF, 16'hFFFF, i == 63);
      for (int i = 0; i < 66; i++)
         send_box(16'(i), 16'(i), 16'(i), i == 65);

      // hold off until all results are in
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat ($urandom_range(10, 1)) @(posedge clock);

      sent = 0;
      while (sent < 1110) begin
         calm = (sent >= 500 && sent < 650);
         n = ($urandom_range(19) == 0) ? $urandom_range(68, 50) : $urandom_range(8, 1);
         send_set(n, $urandom_range(2));
         sent += n;
      end
      start <= 1'b0;
      @(posedge clock);

      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("cuboid_stack_max_height verification clean");
      else
         $display("cuboid_stack_max_height verification failed");
      $finish;
   end

endmodule
